// ----- rtl/core/card_reader_packet_dedup_macros.svh -----
// assertion macros for the card reader packet dedup block
// needs clk_i and rst_ni in the module that uses them
`ifndef CARD_READER_PACKET_DEDUP_MACROS_SVH
`define CARD_READER_PACKET_DEDUP_MACROS_SVH

`ifndef SYNTHESIS
`define CRPD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("crpd assertion failed");
`define CRPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("crpd assertion failed");
`else
`define CRPD_ASSERT(lbl, prop)
`define CRPD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/core/crpd_pkg.sv -----
// types and constants for the card reader packet dedup block
// no dependencies
package crpd_pkg;

  localparam logic [7:0] PKT_CARD_READ = 8'hC1;
  localparam logic [7:0] PKT_DISCOVERY = 8'hF1;

  localparam logic [3:0] POS_TYPE    = 4'd0;
  localparam logic [3:0] POS_IP_B3   = 4'd1;
  localparam logic [3:0] POS_IP_B2   = 4'd2;
  localparam logic [3:0] POS_IP_B1   = 4'd3;
  localparam logic [3:0] POS_IP_B0   = 4'd4;
  localparam logic [3:0] POS_RDR_LO  = 4'd5;
  localparam logic [3:0] POS_RDR_HI  = 4'd6;
  localparam logic [3:0] POS_SEQ_LO  = 4'd7;
  localparam logic [3:0] POS_SEQ_HI  = 4'd8;
  localparam logic [3:0] POS_CARD_B0 = 4'd10;
  localparam logic [3:0] POS_CARD_B1 = 4'd11;
  localparam logic [3:0] POS_CARD_B2 = 4'd12;
  localparam logic [3:0] POS_CARD_B3 = 4'd13;
  localparam logic [3:0] POS_LIMIT   = 4'd14;

  typedef enum logic [2:0] {
    KIND_ACCEPTED  = 3'd0,
    KIND_DUPLICATE = 3'd1,
    KIND_DISC_REPLY = 3'd2,
    KIND_UNKNOWN   = 3'd3,
    KIND_TOO_SHORT = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] reader;
    logic [15:0] seq;
    logic [31:0] card;
    logic [31:0] ip;
  } result_t;

  typedef struct packed {
    logic        seen;
    logic [15:0] seq;
  } entry_t;

endpackage

// ----- rtl/core/crpd_intf.sv -----
// valid/ready channel interfaces for datagram bytes and results
// no dependencies
interface crpd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface crpd_rslt_if;
  logic        valid;
  logic        ready;
  logic [2:0]  result_kind;
  logic [15:0] reader_number;
  logic [15:0] sequence_number;
  logic [31:0] card_number;
  logic [31:0] ip_address;

  modport source (output valid, output result_kind, output reader_number,
                  output sequence_number, output card_number, output ip_address,
                  input ready);
  modport sink (input valid, input result_kind, input reader_number,
                input sequence_number, input card_number, input ip_address,
                output ready);
endinterface

// ----- rtl/core/crpd_seq_table.sv -----
// per-reader last sequence memory with seen bit and clearing sweep after reset
// depends on crpd_pkg
module crpd_seq_table #(
  parameter int unsigned ADDR_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   rd_en_i,
  input  logic [ADDR_BITS-1:0]   rd_addr_i,
  output crpd_pkg::entry_t       rd_data_o,
  input  logic                   wr_en_i,
  input  logic [ADDR_BITS-1:0]   wr_addr_i,
  input  crpd_pkg::entry_t       wr_data_i,
  output logic                   busy_o
);

  localparam int unsigned Depth = 1 << ADDR_BITS;

  crpd_pkg::entry_t     mem [Depth];
  crpd_pkg::entry_t     rd_q;
  logic [ADDR_BITS-1:0] clr_cnt_q, clr_cnt_d;
  logic                 busy_q, busy_d;

  always_comb begin
    clr_cnt_d = clr_cnt_q;
    busy_d    = busy_q;
    if (busy_q) begin
      if (clr_cnt_q == {ADDR_BITS{1'b1}}) begin
        busy_d = 1'b0;
      end else begin
        clr_cnt_d = clr_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
      busy_q    <= 1'b1;
    end else begin
      clr_cnt_q <= clr_cnt_d;
      busy_q    <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[clr_cnt_q] <= '0;
    end else if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;
  assign busy_o    = busy_q;

endmodule

// ----- rtl/core/crpd_out_buf.sv -----
// result register with skid stage driving the result channel
// depends on crpd_pkg, crpd_intf and the macros header
`include "card_reader_packet_dedup_macros.svh"

module crpd_out_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  crpd_pkg::result_t  push_data_i,
  output logic               space_o,
  crpd_rslt_if.source        rslt_o
);

  crpd_pkg::result_t out_q, skid_q;
  logic              out_valid_q, skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || rslt_o.ready) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= push_i;
      end
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || rslt_o.ready) begin
      out_q <= skid_valid_q ? skid_q : push_data_i;
    end else if (push_i) begin
      skid_q <= push_data_i;
    end
  end

  assign space_o                = !skid_valid_q;
  assign rslt_o.valid           = out_valid_q;
  assign rslt_o.result_kind     = out_q.kind;
  assign rslt_o.reader_number   = out_q.reader;
  assign rslt_o.sequence_number = out_q.seq;
  assign rslt_o.card_number     = out_q.card;
  assign rslt_o.ip_address      = out_q.ip;

  `CRPD_ASSERT(a_skid_implies_out, skid_valid_q |-> out_valid_q)
  `CRPD_ASSERT_NEXT(a_stall_fills_skid, out_valid_q && !rslt_o.ready && push_i, skid_valid_q)
  `CRPD_ASSERT_NEXT(a_skid_drains, skid_valid_q && rslt_o.ready, !skid_valid_q)

endmodule

// ----- rtl/core/card_reader_packet_dedup.sv -----
// top level of the card reader packet dedup block: byte capture and judgment
// depends on crpd_pkg, crpd_intf, crpd_seq_table, crpd_out_buf and the macros header
//
// Datagram bytes are taken one per cycle, back to back, unless the table is clearing
// or the skid entry is full, and each byte is judged in the cycle it is accepted;
// a datagram's result is pushed into the output stage at the edge that accepts its
// last byte and is offered from the output register. The per-reader table is a
// single-port-write memory whose registered read is issued when byte 6 (reader
// number high byte) arrives, well before a card read can end at byte 13. After
// reset the seen bits are cleared by a pass over all 2**READER_ID_BITS entries
// (65536 by default), during which no byte is accepted. A two-entry output stage
// (register plus skid) keeps bytes flowing while one result waits to be taken.
`include "card_reader_packet_dedup_macros.svh"

module card_reader_packet_dedup #(
  parameter int unsigned READER_ID_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  crpd_byte_if.sink   byte_i,
  crpd_rslt_if.source rslt_o
);

  logic [3:0]  pos_q, pos_d;
  logic [7:0]  kind_q, kind_d;
  logic [31:0] ip_q, ip_d;
  logic [15:0] reader_q, reader_d;
  logic [15:0] seq_q, seq_d;
  logic [31:0] card_q, card_d;

  logic              in_acc, in_ready, buf_space, tbl_busy;
  logic              tbl_rd_en, tbl_wr_en, dup;
  crpd_pkg::entry_t  tbl_rd_data, tbl_wr_data;
  crpd_pkg::result_t result_d;

  assign in_ready     = !tbl_busy && buf_space;
  assign byte_i.ready = in_ready;
  assign in_acc       = byte_i.valid && in_ready;

  // field capture
  always_comb begin
    kind_d   = kind_q;
    ip_d     = ip_q;
    reader_d = reader_q;
    seq_d    = seq_q;
    card_d   = card_q;
    unique case (pos_q)
      crpd_pkg::POS_TYPE:    kind_d         = byte_i.data_byte;
      crpd_pkg::POS_IP_B3:   ip_d[31:24]    = byte_i.data_byte;
      crpd_pkg::POS_IP_B2:   ip_d[23:16]    = byte_i.data_byte;
      crpd_pkg::POS_IP_B1:   ip_d[15:8]     = byte_i.data_byte;
      crpd_pkg::POS_IP_B0:   ip_d[7:0]      = byte_i.data_byte;
      crpd_pkg::POS_RDR_LO:  reader_d[7:0]  = byte_i.data_byte;
      crpd_pkg::POS_RDR_HI:  reader_d[15:8] = byte_i.data_byte;
      crpd_pkg::POS_SEQ_LO:  seq_d[7:0]     = byte_i.data_byte;
      crpd_pkg::POS_SEQ_HI:  seq_d[15:8]    = byte_i.data_byte;
      crpd_pkg::POS_CARD_B0: card_d[7:0]    = byte_i.data_byte;
      crpd_pkg::POS_CARD_B1: card_d[15:8]   = byte_i.data_byte;
      crpd_pkg::POS_CARD_B2: card_d[23:16]  = byte_i.data_byte;
      crpd_pkg::POS_CARD_B3: card_d[31:24]  = byte_i.data_byte;
      default: ;
    endcase
    pos_d = (pos_q < crpd_pkg::POS_LIMIT) ? pos_q + 4'd1 : pos_q;
  end

  // judgment on the last byte
  assign dup = tbl_rd_data.seen && (tbl_rd_data.seq >= seq_d);

  always_comb begin
    result_d        = '0;
    result_d.kind   = crpd_pkg::KIND_UNKNOWN;
    tbl_wr_en       = 1'b0;
    if (kind_d == crpd_pkg::PKT_CARD_READ) begin
      if (pos_q < crpd_pkg::POS_CARD_B3) begin
        result_d.kind = crpd_pkg::KIND_TOO_SHORT;
      end else begin
        result_d.kind   = dup ? crpd_pkg::KIND_DUPLICATE : crpd_pkg::KIND_ACCEPTED;
        result_d.reader = reader_d;
        result_d.seq    = seq_d;
        result_d.card   = card_d;
        result_d.ip     = ip_d;
        tbl_wr_en       = in_acc && byte_i.last_byte && !dup;
      end
    end else if (kind_d == crpd_pkg::PKT_DISCOVERY) begin
      if (pos_q < crpd_pkg::POS_IP_B0) begin
        result_d.kind = crpd_pkg::KIND_TOO_SHORT;
      end else begin
        result_d.kind = crpd_pkg::KIND_DISC_REPLY;
        result_d.ip   = ip_d;
      end
    end
  end

  assign tbl_rd_en        = in_acc && (pos_q == crpd_pkg::POS_RDR_HI);
  assign tbl_wr_data.seen = 1'b1;
  assign tbl_wr_data.seq  = seq_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      kind_q   <= '0;
      ip_q     <= '0;
      reader_q <= '0;
      seq_q    <= '0;
      card_q   <= '0;
    end else if (in_acc) begin
      if (byte_i.last_byte) begin
        pos_q    <= '0;
        kind_q   <= '0;
        ip_q     <= '0;
        reader_q <= '0;
        seq_q    <= '0;
        card_q   <= '0;
      end else begin
        pos_q    <= pos_d;
        kind_q   <= kind_d;
        ip_q     <= ip_d;
        reader_q <= reader_d;
        seq_q    <= seq_d;
        card_q   <= card_d;
      end
    end
  end

  crpd_seq_table #(
    .ADDR_BITS (READER_ID_BITS)
  ) u_seq_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (tbl_rd_en),
    .rd_addr_i (reader_d[READER_ID_BITS-1:0]),
    .rd_data_o (tbl_rd_data),
    .wr_en_i   (tbl_wr_en),
    .wr_addr_i (reader_d[READER_ID_BITS-1:0]),
    .wr_data_i (tbl_wr_data),
    .busy_o    (tbl_busy)
  );

  crpd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_acc && byte_i.last_byte),
    .push_data_i (result_d),
    .space_o     (buf_space),
    .rslt_o      (rslt_o)
  );

  `CRPD_ASSERT(a_no_byte_while_clearing, tbl_busy |-> !byte_i.ready)
  `CRPD_ASSERT(a_pos_saturates, pos_q <= crpd_pkg::POS_LIMIT)
  `CRPD_ASSERT_NEXT(a_pos_cleared_after_last, in_acc && byte_i.last_byte, pos_q == 4'd0)

endmodule
